FILE: rtl/calendar_clock_add_seconds_top_macros.svh
// Assertion macros for the calendar clock block.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef CALENDAR_CLOCK_ADD_SECONDS_TOP_MACROS_SVH
`define CALENDAR_CLOCK_ADD_SECONDS_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define CCAS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CCAS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ccas_pkg.sv
// Shared types, constants and the month length table for the calendar clock.
// No dependencies; compiled first.
package ccas_pkg;

  // Field widths
  localparam int YEAR_W   = 16;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;

  // Default width of the seconds increment
  localparam int ADD_BITS_DEF = 20;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_YEAR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MONTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOUR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MINUTE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND = 3'd5;

  // Reset values of the start registers
  localparam logic [YEAR_W-1:0]   RST_YEAR   = 16'd1;
  localparam logic [MONTH_W-1:0]  RST_MONTH  = 4'd1;
  localparam logic [DAY_W-1:0]    RST_DAY    = 5'd1;
  localparam logic [HOUR_W-1:0]   RST_HOUR   = 5'd0;
  localparam logic [MINUTE_W-1:0] RST_MINUTE = 6'd0;
  localparam logic [SECOND_W-1:0] RST_SECOND = 6'd0;

  // Calendar limits
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;

  // Time constants
  localparam int SEC_PER_DAY  = 86400;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;
  localparam int TOD_W        = 17;   // seconds of day, below 86400
  localparam int REM_W        = 12;   // seconds within the hour, below 3600

  // hour = ((tod >> 4) * 4661) >> 20, exact for tod below 86400
  localparam int HOUR_IN_W  = 13;
  localparam int HOUR_PROD_W = 26;
  localparam int HOUR_MUL   = 4661;
  localparam int HOUR_SHIFT = 20;

  // minute = ((rem >> 2) * 1093) >> 14, exact for rem below 3600
  localparam int MIN_IN_W   = 10;
  localparam int MIN_PROD_W = 21;
  localparam int MIN_MUL    = 1093;
  localparam int MIN_SHIFT  = 14;

  // year / 25 = (year * 83887) >> 21, exact over 16 bits
  localparam int Q25_W       = 12;
  localparam int Q25_PROD_W  = 33;
  localparam int DIV25_MUL   = 83887;
  localparam int DIV25_SHIFT = 21;
  localparam int DIV25_CHK_W = 17;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;      // capture the seconds-of-day total
    logic load_year;  // copy the start year into the clock
    logic leap_mul;   // year / 25 quotient
    logic leap_chk;   // leap flag from the quotient
    logic load_rest;  // load the time and the clamped month and day
    logic day_step;   // drop one day from the total, advance the date
    logic hour_calc;  // hour from the remaining seconds of day
    logic rem_calc;   // seconds within the hour
    logic min_calc;   // minute from seconds within the hour
    logic finish;     // second, commit time, load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cfg_hit;    // a start register is being written
    logic day_left;   // total still holds a whole day
    logic year_wrap;  // a day step now would cross into a new year
  } dp_sts_t;

  // Days in a month; February depends on the leap flag
  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
    logic [DAY_W-1:0] len;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/ccas_adv_if.sv
// Input channel of the calendar clock: seconds to add.
// Depends on ccas_pkg for the default width; width set by the ADD_BITS parameter.
interface ccas_adv_if #(
  parameter int ADD_BITS = ccas_pkg::ADD_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [ADD_BITS-1:0] add_seconds;

  modport source (output valid, output add_seconds, input ready);
  modport sink   (input valid, input add_seconds, output ready);
endinterface

FILE: rtl/ccas_now_if.sv
// Result channel of the calendar clock: date and time after an advance.
// Depends on ccas_pkg for the field widths.
interface ccas_now_if;
  logic                          valid;
  logic                          ready;
  logic [ccas_pkg::YEAR_W-1:0]   year_out;
  logic [ccas_pkg::MONTH_W-1:0]  month_out;
  logic [ccas_pkg::DAY_W-1:0]    day_out;
  logic [ccas_pkg::HOUR_W-1:0]   hour_out;
  logic [ccas_pkg::MINUTE_W-1:0] minute_out;
  logic [ccas_pkg::SECOND_W-1:0] second_out;

  modport source (output valid, output year_out, output month_out, output day_out,
                  output hour_out, output minute_out, output second_out, input ready);
  modport sink   (input valid, input year_out, input month_out, input day_out,
                  input hour_out, input minute_out, input second_out, output ready);
endinterface

FILE: rtl/calendar_clock_add_seconds_top.sv
// Top level of the calendar clock: controller, datapath and channel wiring.
// Depends on ccas_pkg, ccas_adv_if, ccas_now_if, ccas_ctrl, ccas_dp and the macros header.
//
//   channel  dir   handshake      payload
//   adv      in    valid/ready    add_seconds
//   now      out   valid/ready    year_out month_out day_out hour_out minute_out second_out
//   cfg_*    in    cfg_we         cfg_idx cfg_data
//
// After the input transfer the day loop steps one whole day per cycle, held for a leap refresh
// on each new year entered; the hour, remainder and minute steps follow, then the commit into the
// result register. The next input can transfer once the controller is back to idle. With 20-bit
// increments at most 13 whole days are crossed. A waiting result holds the commit of the next one,
// and input with it. Reset loads 0001-01-01 00:00:00; a start register write reloads the clock
// through year load, leap multiply, leap check and load of the rest, with input held off.
`include "calendar_clock_add_seconds_top_macros.svh"

module calendar_clock_add_seconds_top #(
  parameter int ADD_BITS = ccas_pkg::ADD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  ccas_adv_if.sink                        adv,
  ccas_now_if.source                      now,
  input  logic                            cfg_we,
  input  logic [ccas_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ccas_pkg::CFG_DATA_W-1:0] cfg_data
);

  ccas_pkg::dp_cmd_t cmd;
  ccas_pkg::dp_sts_t sts;
  logic [ADD_BITS-1:0] add_seconds;

  assign add_seconds = adv.add_seconds;

  ccas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (adv.valid),
    .in_ready  (adv.ready),
    .out_valid (now.valid),
    .out_ready (now.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ccas_dp #(
    .ADD_BITS (ADD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_data    (cfg_data),
    .add_seconds (add_seconds),
    .cmd         (cmd),
    .sts         (sts),
    .year_out    (now.year_out),
    .month_out   (now.month_out),
    .day_out     (now.day_out),
    .hour_out    (now.hour_out),
    .minute_out  (now.minute_out),
    .second_out  (now.second_out)
  );

  // Every result holds a month in range, a day of at least one and a normalized time
  `CCAS_ASSERT_NOW(a_result_range, now.valid, (now.month_out >= ccas_pkg::MONTH_JAN) && (now.month_out <= ccas_pkg::MONTH_DEC) && (now.day_out >= ccas_pkg::DAY_FIRST) && (now.hour_out < 5'd24) && (now.minute_out < 6'd60) && (now.second_out < 6'd60), "result field out of range")

  // One item at a time: no transfer in the cycle after one
  `CCAS_ASSERT_NEXT(a_one_item, adv.valid && adv.ready, !adv.ready, "input taken while busy")

  // A reload holds off input
  `CCAS_ASSERT_NEXT(a_reload_block, sts.cfg_hit, !adv.ready, "input open during reload")

  // Entering a new year refreshes the leap flag before the next day step
  `CCAS_ASSERT_NEXT(a_leap_refresh, cmd.day_step && sts.year_wrap, cmd.leap_mul && !cmd.day_step, "leap flag not refreshed")

endmodule

FILE: rtl/ccas_ctrl.sv
// Sequencer of the calendar clock: reload, day loop and time split.
// Depends on ccas_pkg for the command and status structs.
module ccas_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ccas_pkg::dp_sts_t sts,
  output ccas_pkg::dp_cmd_t cmd
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_LD_YEAR = 11'b000_0000_0010,
    ST_LD_MUL  = 11'b000_0000_0100,
    ST_LD_CHK  = 11'b000_0000_1000,
    ST_LD_SET  = 11'b000_0001_0000,
    ST_DAYS    = 11'b000_0010_0000,
    ST_YR_MUL  = 11'b000_0100_0000,
    ST_YR_CHK  = 11'b000_1000_0000,
    ST_REM     = 11'b001_0000_0000,
    ST_MIN     = 11'b010_0000_0000,
    ST_FIN     = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_DAYS;
        end
      end
      ST_LD_YEAR: begin
        cmd.load_year = 1'b1;
        state_next    = ST_LD_MUL;
      end
      ST_LD_MUL: begin
        cmd.leap_mul = 1'b1;
        state_next   = ST_LD_CHK;
      end
      ST_LD_CHK: begin
        cmd.leap_chk = 1'b1;
        state_next   = ST_LD_SET;
      end
      ST_LD_SET: begin
        cmd.load_rest = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_DAYS: begin
        if (sts.day_left) begin
          cmd.day_step = 1'b1;
          if (sts.year_wrap) begin
            state_next = ST_YR_MUL;
          end
        end else begin
          cmd.hour_calc = 1'b1;
          state_next    = ST_REM;
        end
      end
      ST_YR_MUL: begin
        cmd.leap_mul = 1'b1;
        state_next   = ST_YR_CHK;
      end
      ST_YR_CHK: begin
        cmd.leap_chk = 1'b1;
        state_next   = ST_DAYS;
      end
      ST_REM: begin
        cmd.rem_calc = 1'b1;
        state_next   = ST_MIN;
      end
      ST_MIN: begin
        cmd.min_calc = 1'b1;
        state_next   = ST_FIN;
      end
      ST_FIN: begin
        // Hold until the result register is free
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // A start register write restarts the reload, also in the middle of an advance
    if (sts.cfg_hit) begin
      state_next = ST_LD_YEAR;
    end
  end

  // Result valid: set on commit, drop on transfer
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/ccas_dp.sv
// Datapath of the calendar clock: start registers, clock state, day loop
// arithmetic, time split and result register. Depends on ccas_pkg.
module ccas_dp #(
  parameter int ADD_BITS = ccas_pkg::ADD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ccas_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [ccas_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [ADD_BITS-1:0]                 add_seconds,
  input  ccas_pkg::dp_cmd_t                   cmd,
  output ccas_pkg::dp_sts_t                   sts,
  output logic [ccas_pkg::YEAR_W-1:0]         year_out,
  output logic [ccas_pkg::MONTH_W-1:0]        month_out,
  output logic [ccas_pkg::DAY_W-1:0]          day_out,
  output logic [ccas_pkg::HOUR_W-1:0]         hour_out,
  output logic [ccas_pkg::MINUTE_W-1:0]       minute_out,
  output logic [ccas_pkg::SECOND_W-1:0]       second_out
);

  // Time of day can reach 115443 from an unnormalized start, so one bit more
  localparam int TOT_W = ADD_BITS + 1;

  // Start registers
  logic [ccas_pkg::YEAR_W-1:0]   start_year;
  logic [ccas_pkg::MONTH_W-1:0]  start_month;
  logic [ccas_pkg::DAY_W-1:0]    start_day;
  logic [ccas_pkg::HOUR_W-1:0]   start_hour;
  logic [ccas_pkg::MINUTE_W-1:0] start_minute;
  logic [ccas_pkg::SECOND_W-1:0] start_second;

  // Clock state
  logic [ccas_pkg::YEAR_W-1:0]   cur_year;
  logic [ccas_pkg::MONTH_W-1:0]  cur_month;
  logic [ccas_pkg::DAY_W-1:0]    cur_day;
  logic [ccas_pkg::HOUR_W-1:0]   cur_hour;
  logic [ccas_pkg::MINUTE_W-1:0] cur_minute;
  logic [ccas_pkg::SECOND_W-1:0] cur_second;
  logic                          leap;

  // Work registers
  logic [TOT_W-1:0]              total;
  logic [ccas_pkg::Q25_W-1:0]    q25;
  logic [ccas_pkg::REM_W-1:0]    rem;

  // Combinational terms
  logic [TOT_W-1:0]                    total_start;
  logic [ccas_pkg::DAY_W-1:0]          cur_len;
  logic [ccas_pkg::MONTH_W-1:0]        ld_month;
  logic [ccas_pkg::DAY_W-1:0]          ld_len;
  logic [ccas_pkg::DAY_W-1:0]          ld_day;
  logic [ccas_pkg::Q25_PROD_W-1:0]     q25_prod;
  logic                                div25;
  logic [ccas_pkg::TOD_W-1:0]          tod;
  logic [ccas_pkg::HOUR_PROD_W-1:0]    hour_prod;
  logic [ccas_pkg::MIN_PROD_W-1:0]     min_prod;
  logic [ccas_pkg::SECOND_W-1:0]       sec_calc;

  // Status
  assign sts.cfg_hit   = cfg_we && (cfg_idx <= ccas_pkg::REG_SECOND);
  assign cur_len       = ccas_pkg::days_in_month(cur_month, leap);
  assign sts.day_left  = (total >= TOT_W'(ccas_pkg::SEC_PER_DAY));
  assign sts.year_wrap = (cur_day >= cur_len) && (cur_month >= ccas_pkg::MONTH_DEC);

  // Seconds of day plus increment
  assign total_start = TOT_W'(cur_hour) * TOT_W'(ccas_pkg::SEC_PER_HOUR)
                     + TOT_W'(cur_minute) * TOT_W'(ccas_pkg::SEC_PER_MIN)
                     + TOT_W'(cur_second) + TOT_W'(add_seconds);

  // Leap test: divisible by 25 through a reciprocal multiply
  assign q25_prod = ccas_pkg::Q25_PROD_W'(cur_year)
                  * ccas_pkg::Q25_PROD_W'(ccas_pkg::DIV25_MUL);
  assign div25    = (ccas_pkg::DIV25_CHK_W'(q25) * ccas_pkg::DIV25_CHK_W'(25)
                     == ccas_pkg::DIV25_CHK_W'(cur_year));

  // Clamp the start month and day
  always_comb begin
    ld_month = start_month;
    if (start_month < ccas_pkg::MONTH_JAN) begin
      ld_month = ccas_pkg::MONTH_JAN;
    end else if (start_month > ccas_pkg::MONTH_DEC) begin
      ld_month = ccas_pkg::MONTH_DEC;
    end
    ld_len = ccas_pkg::days_in_month(ld_month, leap);
    ld_day = start_day;
    if (start_day < ccas_pkg::DAY_FIRST) begin
      ld_day = ccas_pkg::DAY_FIRST;
    end else if (start_day > ld_len) begin
      ld_day = ld_len;
    end
  end

  // Split the seconds of day
  assign tod       = total[ccas_pkg::TOD_W-1:0];
  assign hour_prod = ccas_pkg::HOUR_PROD_W'(tod[ccas_pkg::TOD_W-1:4])
                   * ccas_pkg::HOUR_PROD_W'(ccas_pkg::HOUR_MUL);
  assign min_prod  = ccas_pkg::MIN_PROD_W'(rem[ccas_pkg::REM_W-1:2])
                   * ccas_pkg::MIN_PROD_W'(ccas_pkg::MIN_MUL);
  assign sec_calc  = ccas_pkg::SECOND_W'(rem - ccas_pkg::REM_W'(cur_minute)
                                         * ccas_pkg::REM_W'(ccas_pkg::SEC_PER_MIN));

  // Start registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_year   <= ccas_pkg::RST_YEAR;
      start_month  <= ccas_pkg::RST_MONTH;
      start_day    <= ccas_pkg::RST_DAY;
      start_hour   <= ccas_pkg::RST_HOUR;
      start_minute <= ccas_pkg::RST_MINUTE;
      start_second <= ccas_pkg::RST_SECOND;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ccas_pkg::REG_YEAR:   start_year   <= cfg_data[ccas_pkg::YEAR_W-1:0];
        ccas_pkg::REG_MONTH:  start_month  <= cfg_data[ccas_pkg::MONTH_W-1:0];
        ccas_pkg::REG_DAY:    start_day    <= cfg_data[ccas_pkg::DAY_W-1:0];
        ccas_pkg::REG_HOUR:   start_hour   <= cfg_data[ccas_pkg::HOUR_W-1:0];
        ccas_pkg::REG_MINUTE: start_minute <= cfg_data[ccas_pkg::MINUTE_W-1:0];
        ccas_pkg::REG_SECOND: start_second <= cfg_data[ccas_pkg::SECOND_W-1:0];
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // Clock state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_year   <= ccas_pkg::RST_YEAR;
      cur_month  <= ccas_pkg::RST_MONTH;
      cur_day    <= ccas_pkg::RST_DAY;
      cur_hour   <= ccas_pkg::RST_HOUR;
      cur_minute <= ccas_pkg::RST_MINUTE;
      cur_second <= ccas_pkg::RST_SECOND;
      leap       <= 1'b0;
    end else begin
      if (cmd.load_year) begin
        cur_year <= start_year;
      end
      if (cmd.leap_chk) begin
        leap <= ((cur_year[1:0] == 2'd0) && !div25) || ((cur_year[3:0] == 4'd0) && div25);
      end
      if (cmd.load_rest) begin
        cur_month  <= ld_month;
        cur_day    <= ld_day;
        cur_hour   <= start_hour;
        cur_minute <= start_minute;
        cur_second <= start_second;
      end
      // Advance the date by one day
      if (cmd.day_step) begin
        if (cur_day >= cur_len) begin
          cur_day <= ccas_pkg::DAY_FIRST;
          if (cur_month >= ccas_pkg::MONTH_DEC) begin
            cur_month <= ccas_pkg::MONTH_JAN;
            cur_year  <= cur_year + 1'b1;
          end else begin
            cur_month <= cur_month + 1'b1;
          end
        end else begin
          cur_day <= cur_day + 1'b1;
        end
      end
      if (cmd.hour_calc) begin
        cur_hour <= ccas_pkg::HOUR_W'(hour_prod >> ccas_pkg::HOUR_SHIFT);
      end
      if (cmd.min_calc) begin
        cur_minute <= ccas_pkg::MINUTE_W'(min_prod >> ccas_pkg::MIN_SHIFT);
      end
      if (cmd.finish) begin
        cur_second <= sec_calc;
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      total <= total_start;
    end else if (cmd.day_step) begin
      total <= total - TOT_W'(ccas_pkg::SEC_PER_DAY);
    end
    if (cmd.leap_mul) begin
      q25 <= ccas_pkg::Q25_W'(q25_prod >> ccas_pkg::DIV25_SHIFT);
    end
    if (cmd.rem_calc) begin
      rem <= ccas_pkg::REM_W'(tod - ccas_pkg::TOD_W'(cur_hour)
                                    * ccas_pkg::TOD_W'(ccas_pkg::SEC_PER_HOUR));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      year_out   <= cur_year;
      month_out  <= cur_month;
      day_out    <= cur_day;
      hour_out   <= cur_hour;
      minute_out <= cur_minute;
      second_out <= sec_calc;
    end
  end

endmodule

FILE: tb/calendar_clock_add_seconds_top_tb.sv
`timescale 1ns / 1ps
// Testbench for calendar_clock_add_seconds_top: table-driven corner cases, then random phases.
// Depends on ccas_pkg, ccas_adv_if, ccas_now_if and the RTL; results checked in order.

module calendar_clock_add_seconds_top_tb;
  import ccas_pkg::*;

  localparam int ADD_BITS = ADD_BITS_DEF;
  localparam logic [ADD_BITS-1:0] MAX_ADD = {ADD_BITS{1'b1}};
  localparam int NUM_DIR = 24;
  localparam int NUM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int DRAIN_CYCLES = 40;
  localparam longint LIMIT_NS = 5_000_000;

  // Indexes past the last start register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] START_REGS [6] =
    '{REG_YEAR, REG_MONTH, REG_DAY, REG_HOUR, REG_MINUTE, REG_SECOND};

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } stamp_t;

  // One corner case: optional reload of all start registers, optional spare
  // writes, then one advance; the result is typed in where it is obvious
  typedef struct {
    bit                  reload;
    bit                  spare;
    stamp_t              start;
    logic [ADD_BITS-1:0] secs;
    bit                  typed;
    stamp_t              want;
  } corner_row_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ccas_adv_if #(.ADD_BITS(ADD_BITS)) adv_ch ();
  ccas_now_if now_ch ();

  calendar_clock_add_seconds_top #(.ADD_BITS(ADD_BITS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv_ch),
    .now      (now_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Predicted clock and the start registers behind it
  logic [CFG_DATA_W-1:0] start_val [6];
  logic [YEAR_W-1:0]     cal_year;
  logic [MONTH_W-1:0]    cal_month;
  logic [DAY_W-1:0]      cal_day;
  logic [HOUR_W-1:0]     cal_hour;
  logic [MINUTE_W-1:0]   cal_minute;
  logic [SECOND_W-1:0]   cal_second;

  stamp_t pending_stamps [$];
  int     mismatches;
  int     results_seen;
  bit     quiet;
  int     ready_hold;

  function automatic stamp_t clock_at(int y, int mo, int d, int h, int mi, int s);
    stamp_t t;
    t.year   = YEAR_W'(y);
    t.month  = MONTH_W'(mo);
    t.day    = DAY_W'(d);
    t.hour   = HOUR_W'(h);
    t.minute = MINUTE_W'(mi);
    t.second = SECOND_W'(s);
    return t;
  endfunction

  corner_row_t corner_tab [NUM_DIR] = '{
    '{1'b0, 1'b0, '0, 20'd0, 1'b1, clock_at(1, 1, 1, 0, 0, 0)},
    '{1'b0, 1'b0, '0, 20'd1, 1'b1, clock_at(1, 1, 1, 0, 0, 1)},
    '{1'b0, 1'b0, '0, 20'd86399, 1'b1, clock_at(1, 1, 2, 0, 0, 0)},
    '{1'b0, 1'b0, '0, MAX_ADD, 1'b0, '0},
    '{1'b1, 1'b0, clock_at(65535, 12, 31, 23, 59, 59), 20'd1, 1'b1, clock_at(0, 1, 1, 0, 0, 0)},
    '{1'b1, 1'b0, clock_at(0, 2, 28, 23, 59, 59), 20'd1, 1'b1, clock_at(0, 2, 29, 0, 0, 0)},
    '{1'b1, 1'b0, clock_at(1900, 2, 28, 23, 59, 59), 20'd1, 1'b1, clock_at(1900, 3, 1, 0, 0, 0)},
    '{1'b1, 1'b0, clock_at(2000, 2, 28, 23, 59, 59), 20'd1, 1'b1, clock_at(2000, 2, 29, 0, 0, 0)},
    '{1'b1, 1'b0, clock_at(2100, 2, 28, 23, 59, 59), 20'd1, 1'b1, clock_at(2100, 3, 1, 0, 0, 0)},
    '{1'b1, 1'b0, clock_at(2024, 2, 29, 12, 0, 0), 20'd86400, 1'b1,
      clock_at(2024, 3, 1, 12, 0, 0)},
    '{1'b1, 1'b0, clock_at(2023, 2, 31, 0, 0, 0), 20'd0, 1'b1, clock_at(2023, 2, 28, 0, 0, 0)},
    '{1'b1, 1'b0, clock_at(2024, 2, 30, 0, 0, 0), 20'd0, 1'b1, clock_at(2024, 2, 29, 0, 0, 0)},
    '{1'b1, 1'b0, clock_at(2021, 0, 0, 6, 30, 0), 20'd0, 1'b1, clock_at(2021, 1, 1, 6, 30, 0)},
    '{1'b1, 1'b0, clock_at(2021, 15, 31, 0, 0, 0), 20'd0, 1'b1,
      clock_at(2021, 12, 31, 0, 0, 0)},
    '{1'b1, 1'b0, clock_at(2021, 13, 30, 0, 0, 0), 20'd0, 1'b1,
      clock_at(2021, 12, 30, 0, 0, 0)},
    '{1'b1, 1'b0, clock_at(2020, 4, 30, 31, 63, 63), 20'd0, 1'b1, clock_at(2020, 5, 1, 8, 4, 3)},
    '{1'b0, 1'b0, '0, MAX_ADD, 1'b0, '0},
    '{1'b1, 1'b0, clock_at(65535, 12, 25, 23, 59, 59), MAX_ADD, 1'b0, '0},
    '{1'b0, 1'b1, '0, 20'd0, 1'b0, '0},
    '{1'b1, 1'b0, clock_at(1999, 12, 31, 23, 59, 59), 20'd1, 1'b1, clock_at(2000, 1, 1, 0, 0, 0)},
    '{1'b1, 1'b0, clock_at(2024, 1, 31, 23, 0, 0), 20'd3600, 1'b1, clock_at(2024, 2, 1, 0, 0, 0)},
    '{1'b1, 1'b0, clock_at(2023, 11, 30, 23, 59, 59), 20'd1, 1'b1,
      clock_at(2023, 12, 1, 0, 0, 0)},
    '{1'b1, 1'b0, clock_at(0, 0, 0, 0, 0, 0), 20'hAAAAA, 1'b0, '0},
    '{1'b0, 1'b0, '0, 20'h55555, 1'b0, '0}
  };

  // Gregorian month length
  function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0] y,
                                                  input logic [MONTH_W-1:0] m);
    logic leap;
    logic [DAY_W-1:0] len;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Load the clock from the start registers, clamping month and day
  function automatic void reload_calendar();
    logic [DAY_W-1:0] len;
    cal_year  = start_val[REG_YEAR][YEAR_W-1:0];
    cal_month = start_val[REG_MONTH][MONTH_W-1:0];
    if (cal_month < MONTH_JAN) cal_month = MONTH_JAN;
    if (cal_month > MONTH_DEC) cal_month = MONTH_DEC;
    cal_day = start_val[REG_DAY][DAY_W-1:0];
    len = month_days(cal_year, cal_month);
    if (cal_day < DAY_FIRST) cal_day = DAY_FIRST;
    if (cal_day > len) cal_day = len;
    cal_hour   = start_val[REG_HOUR][HOUR_W-1:0];
    cal_minute = start_val[REG_MINUTE][MINUTE_W-1:0];
    cal_second = start_val[REG_SECOND][SECOND_W-1:0];
  endfunction

  // Add seconds to the predicted clock and return the new date and time
  function automatic stamp_t advance_calendar(input logic [ADD_BITS-1:0] secs);
    int unsigned total;
    int unsigned tod;
    int unsigned days_over;
    stamp_t res;
    total = cal_hour * SEC_PER_HOUR + cal_minute * SEC_PER_MIN + cal_second + secs;
    days_over = total / SEC_PER_DAY;
    tod = total % SEC_PER_DAY;
    repeat (days_over) begin
      if (cal_day >= month_days(cal_year, cal_month)) begin
        cal_day = DAY_FIRST;
        if (cal_month >= MONTH_DEC) begin
          cal_month = MONTH_JAN;
          cal_year  = cal_year + 1'b1;
        end else begin
          cal_month = cal_month + 1'b1;
        end
      end else begin
        cal_day = cal_day + 1'b1;
      end
    end
    cal_hour   = HOUR_W'(tod / SEC_PER_HOUR);
    tod        = tod % SEC_PER_HOUR;
    cal_minute = MINUTE_W'(tod / SEC_PER_MIN);
    cal_second = SECOND_W'(tod % SEC_PER_MIN);
    res = '{cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second};
    return res;
  endfunction

  // Keep the low w bits of v, fill the rest with noise
  function automatic logic [CFG_DATA_W-1:0] pad_high(input logic [CFG_DATA_W-1:0] v,
                                                     input int w);
    logic [CFG_DATA_W-1:0] r;
    r = CFG_DATA_W'($urandom);
    return (r << w) | (v & ((16'd1 << w) - 16'd1));
  endfunction

  // Random start value, biased to the edges of the calendar
  function automatic logic [CFG_DATA_W-1:0] pick_start(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    case (idx)
      REG_YEAR: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = '1;
          2: v = CFG_DATA_W'(100 * $urandom_range(0, 655));
          3: v = CFG_DATA_W'($urandom_range(1896, 2104));
          default: ;
        endcase
      end
      REG_MONTH:  if ($urandom_range(0, 4) != 0) v[MONTH_W-1:0] = MONTH_W'($urandom_range(1, 12));
      REG_DAY:    if ($urandom_range(0, 4) != 0) v[DAY_W-1:0] = DAY_W'($urandom_range(25, 31));
      REG_HOUR:   if ($urandom_range(0, 4) != 0) v[HOUR_W-1:0] = HOUR_W'($urandom_range(20, 23));
      REG_MINUTE: if ($urandom_range(0, 4) != 0)
                    v[MINUTE_W-1:0] = MINUTE_W'($urandom_range(0, 59));
      REG_SECOND: if ($urandom_range(0, 4) != 0)
                    v[SECOND_W-1:0] = SECOND_W'($urandom_range(50, 59));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [ADD_BITS-1:0] pick_seconds();
    logic [ADD_BITS-1:0] s;
    case ($urandom_range(0, 7))
      0: s = '0;
      1: s = ADD_BITS'($urandom_range(1, 59));
      2: s = ADD_BITS'($urandom_range(60, 7200));
      3: s = ADD_BITS'(SEC_PER_DAY * $urandom_range(1, 12) + $urandom_range(0, 2) - 1);
      4: s = MAX_ADD;
      default: s = ADD_BITS'($urandom_range(0, MAX_ADD));
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ERROR: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [YEAR_W-1:0] got,
                             input logic [YEAR_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                results_seen, name, got, want));
  endtask

  // Write one register; the predictor follows at the same edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx <= REG_SECOND) begin
      start_val[idx] = data;
      reload_calendar();
    end
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_idle();
    adv_ch.valid <= 1'b0;
    while (pending_stamps.size() != 0) @(posedge clk);
  endtask

  // Present one increment, wait for its transfer, queue its expected clock
  task automatic send_item(input logic [ADD_BITS-1:0] secs, input bit typed,
                           input stamp_t want);
    stamp_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      adv_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    adv_ch.valid       <= 1'b1;
    adv_ch.add_seconds <= secs;
    @(posedge clk);
    while (!adv_ch.ready) @(posedge clk);
    predicted = advance_calendar(secs);
    pending_stamps.push_back(typed ? want : predicted);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

  // Result side: stall in random bursts; no new stall starts once the run goes quiet
  initial begin
    now_ch.ready <= 1'b0;
    ready_hold = 0;
    forever begin
      @(posedge clk);
      if (ready_hold == 0) begin
        if (quiet || $urandom_range(0, 2) != 0) begin
          now_ch.ready <= 1'b1;
          ready_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 20);
        end else begin
          now_ch.ready <= 1'b0;
          ready_hold = $urandom_range(1, 9);
        end
      end else begin
        ready_hold--;
      end
    end
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    stamp_t want;
    if (!rst && now_ch.valid && now_ch.ready) begin
      if (pending_stamps.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_stamps.pop_front();
        check_field("year", now_ch.year_out, want.year);
        check_field("month", YEAR_W'(now_ch.month_out), YEAR_W'(want.month));
        check_field("day", YEAR_W'(now_ch.day_out), YEAR_W'(want.day));
        check_field("hour", YEAR_W'(now_ch.hour_out), YEAR_W'(want.hour));
        check_field("minute", YEAR_W'(now_ch.minute_out), YEAR_W'(want.minute));
        check_field("second", YEAR_W'(now_ch.second_out), YEAR_W'(want.second));
      end
      results_seen++;
    end
  end

  initial begin
    corner_row_t row;
    bit wrote;
    mismatches   = 0;
    results_seen = 0;
    quiet        = 1'b0;
    rst                <= 1'b1;
    adv_ch.valid       <= 1'b0;
    adv_ch.add_seconds <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= REG_YEAR;
    cfg_data <= '0;
    start_val[REG_YEAR]   = RST_YEAR;
    start_val[REG_MONTH]  = CFG_DATA_W'(RST_MONTH);
    start_val[REG_DAY]    = CFG_DATA_W'(RST_DAY);
    start_val[REG_HOUR]   = CFG_DATA_W'(RST_HOUR);
    start_val[REG_MINUTE] = CFG_DATA_W'(RST_MINUTE);
    start_val[REG_SECOND] = CFG_DATA_W'(RST_SECOND);
    reload_calendar();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Corner cases from the table
    foreach (corner_tab[i]) begin
      row = corner_tab[i];
      if (row.reload || row.spare) begin
        wait_idle();
        if (row.reload) begin
          write_reg(REG_YEAR, row.start.year);
          write_reg(REG_MONTH, pad_high(CFG_DATA_W'(row.start.month), MONTH_W));
          write_reg(REG_DAY, pad_high(CFG_DATA_W'(row.start.day), DAY_W));
          write_reg(REG_HOUR, pad_high(CFG_DATA_W'(row.start.hour), HOUR_W));
          write_reg(REG_MINUTE, pad_high(CFG_DATA_W'(row.start.minute), MINUTE_W));
          write_reg(REG_SECOND, pad_high(CFG_DATA_W'(row.start.second), SECOND_W));
        end
        if (row.spare) begin
          write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
          write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        end
        cfg_we <= 1'b0;
      end
      send_item(row.secs, row.typed, row.want);
    end

    // Random phases, each behind new values in at least one start register
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      quiet = (ph == NUM_PHASES - 1);
      wrote = 1'b0;
      while (!wrote) begin
        foreach (START_REGS[k]) begin
          if ($urandom_range(0, 1) != 0) begin
            write_reg(START_REGS[k], pick_start(START_REGS[k]));
            wrote = 1'b1;
          end
        end
      end
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
      cfg_we <= 1'b0;
      repeat (ITEMS_PER_PHASE) send_item(pick_seconds(), 1'b0, '0);
    end

    // Drain and let any stray result show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_stamps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
